// ===== sv/json_string_unescape_utf8_top_defines.svh =====
// ----------------------------------------------------------------------------
// JSON string decoder assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication
`define JSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication
`define JSU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helpers shared by the JSON string decoder modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;

    // Job queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Width of a job value: a full code point
    localparam int CP_W = 21;

    // Result kinds on the output stream
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NO_QUOTE = 3'd0;
    localparam logic [2:0] ERR_UNTERM   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_NO_LOW   = 3'd4;
    localparam logic [2:0] ERR_BAD_LOW  = 3'd5;

    // Job kinds
    localparam logic [1:0] JOB_RAW  = 2'd0;  // one byte as is
    localparam logic [1:0] JOB_CP   = 2'd1;  // code point, UTF-8 encoded
    localparam logic [1:0] JOB_DONE = 2'd2;
    localparam logic [1:0] JOB_ERR  = 2'd3;  // error code in val[2:0]

    typedef struct packed {
        logic [1:0]      kind;
        logic [CP_W-1:0] val;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Hex digit decode: {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ===== sv/json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// Streaming decoder for one quoted JSON string into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The block takes one source byte per input beat (tlast marks end of input)
// and, while its four-entry job queue has room, accepts a beat every cycle.
// The front parser handles quotes, escapes and \uXXXX surrogate pairs and
// posts at most one job per beat; the back part emits one result beat per
// cycle while the output is not stalled, so a code point yields one to four
// result beats (its UTF-8 length), while a raw byte, the done mark or an
// error yields one. The sustained rate is therefore one input beat per cycle
// as long as the output averages one result per input; longer bursts are
// absorbed by the queue and then hold off tready. Results are loaded into
// the output register from the job at the queue head. tlast on the output
// flags the final result of each input beat; beats that cause no result
// (opening quote, backslash, leading hex digits, discarded bytes) give none.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_top_defines.svh"

module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,   // end_mark
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] out_kind
    output logic                   m_axis_tlast    // last_of_run
);

    t_push q_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_job  q_head;

    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (q_push)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Checks
    `JSU_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
    `JSU_ASSERT_IMP(a_push_not_full, q_push.valid, !q_full)
    `JSU_ASSERT_IMP(a_mark_is_last, m_axis_tvalid && m_axis_tuser != KIND_BYTE, m_axis_tlast)

endmodule

// ===== sv/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Accepts source beats, tracks the string/escape/hex state and posts one
// job per beat that yields output into the job queue.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic                  s_axis_tlast,   // end_mark
    input  logic                  i_q_full,
    output t_push                 o_push
);

    // Phase codes
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_STR  = 4'd1;
    localparam logic [3:0] PH_ESC  = 4'd2;
    localparam logic [3:0] PH_HX0  = 4'd3;
    localparam logic [3:0] PH_HX1  = 4'd4;
    localparam logic [3:0] PH_HX2  = 4'd5;
    localparam logic [3:0] PH_HX3  = 4'd6;
    localparam logic [3:0] PH_LBS  = 4'd7;
    localparam logic [3:0] PH_LU   = 4'd8;
    localparam logic [3:0] PH_LX0  = 4'd9;
    localparam logic [3:0] PH_LX1  = 4'd10;
    localparam logic [3:0] PH_LX2  = 4'd11;
    localparam logic [3:0] PH_LX3  = 4'd12;
    localparam logic [3:0] PH_DISC = 4'd13;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_acc,   n_acc;
    logic [9:0]  r_hh,    n_hh;

    logic        accept;
    logic [7:0]  c;
    logic        at_end;
    logic [4:0]  hexd;
    logic [15:0] acc_n;
    logic        fail;
    logic [2:0]  fcode;
    logic [10:0] cp_hi;

    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign at_end        = s_axis_tlast;
    assign hexd          = hex_digit(c);
    assign acc_n         = {r_acc[11:0], hexd[3:0]};
    // 0x10000 + (high << 10): upper bits of the paired code point
    assign cp_hi         = {1'b0, r_hh} + 11'd64;

    // Next state and job
    always_comb begin
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_hh          = r_hh;
        fail          = 1'b0;
        fcode         = ERR_NO_QUOTE;
        o_push.valid  = 1'b0;
        o_push.job    = '0;
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (at_end || c != CH_QUOTE) begin
                        fail  = 1'b1;
                        fcode = ERR_NO_QUOTE;
                    end else begin
                        n_phase = PH_STR;
                    end
                end
                PH_STR: begin
                    if (at_end) begin
                        fail  = 1'b1;
                        fcode = ERR_UNTERM;
                    end else if (c == CH_QUOTE) begin
                        o_push.valid    = 1'b1;
                        o_push.job.kind = JOB_DONE;
                        n_phase         = PH_IDLE;
                    end else if (c == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_push.valid    = 1'b1;
                        o_push.job.kind = JOB_RAW;
                        o_push.job.val  = CP_W'(c);
                    end
                end
                PH_ESC: begin
                    if (at_end) begin
                        fail  = 1'b1;
                        fcode = ERR_UNTERM;
                    end else begin
                        o_push.job.kind = JOB_RAW;
                        n_phase         = PH_STR;
                        o_push.valid    = 1'b1;
                        case (c)
                            CH_QUOTE: o_push.job.val = CP_W'(8'h22);
                            CH_BSL:   o_push.job.val = CP_W'(8'h5c);
                            CH_SLASH: o_push.job.val = CP_W'(8'h2f);
                            CH_B:     o_push.job.val = CP_W'(8'h08);
                            CH_F:     o_push.job.val = CP_W'(8'h0c);
                            CH_N:     o_push.job.val = CP_W'(8'h0a);
                            CH_R:     o_push.job.val = CP_W'(8'h0d);
                            CH_T:     o_push.job.val = CP_W'(8'h09);
                            default: begin
                                o_push.valid = 1'b0;
                                if (c == CH_U) begin
                                    n_acc   = 16'd0;
                                    n_phase = PH_HX0;
                                end else begin
                                    fail  = 1'b1;
                                    fcode = ERR_BAD_ESC;
                                end
                            end
                        endcase
                    end
                end
                PH_HX0, PH_HX1, PH_HX2, PH_HX3,
                PH_LX0, PH_LX1, PH_LX2, PH_LX3: begin
                    if (at_end) begin
                        fail  = 1'b1;
                        fcode = ERR_UNTERM;
                    end else if (!hexd[4]) begin
                        fail  = 1'b1;
                        fcode = ERR_BAD_HEX;
                    end else if (r_phase != PH_HX3 && r_phase != PH_LX3) begin
                        n_acc   = acc_n;
                        n_phase = r_phase + 4'd1;
                    end else if (r_phase == PH_HX3) begin
                        n_acc = 16'd0;
                        // High surrogate: keep its low ten bits, await the pair
                        if (acc_n[15:10] == 6'b110110) begin
                            n_hh    = acc_n[9:0];
                            n_phase = PH_LBS;
                        end else begin
                            o_push.valid    = 1'b1;
                            o_push.job.kind = JOB_CP;
                            o_push.job.val  = CP_W'(acc_n);
                            n_phase         = PH_STR;
                        end
                    end else if (acc_n[15:10] == 6'b110111) begin
                        o_push.valid    = 1'b1;
                        o_push.job.kind = JOB_CP;
                        o_push.job.val  = {cp_hi, acc_n[9:0]};
                        n_acc           = 16'd0;
                        n_hh            = 10'd0;
                        n_phase         = PH_STR;
                    end else begin
                        fail  = 1'b1;
                        fcode = ERR_BAD_LOW;
                    end
                end
                PH_LBS: begin
                    if (at_end || c != CH_BSL) begin
                        fail  = 1'b1;
                        fcode = ERR_NO_LOW;
                    end else begin
                        n_phase = PH_LU;
                    end
                end
                PH_LU: begin
                    if (at_end || c != CH_U) begin
                        fail  = 1'b1;
                        fcode = ERR_NO_LOW;
                    end else begin
                        n_acc   = 16'd0;
                        n_phase = PH_LX0;
                    end
                end
                default: begin
                    // discard and unused codes: wait for the end mark
                    if (at_end) begin
                        n_phase = PH_IDLE;
                        n_acc   = 16'd0;
                        n_hh    = 10'd0;
                    end
                end
            endcase

            // Common error exit
            if (fail) begin
                o_push.valid    = 1'b1;
                o_push.job.kind = JOB_ERR;
                o_push.job.val  = CP_W'(fcode);
                n_phase         = at_end ? PH_IDLE : PH_DISC;
                n_acc           = 16'd0;
                n_hh            = 10'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= 16'd0;
            r_hh    <= 10'd0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_hh    <= n_hh;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small first-word-fall-through job queue between front and back.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_job  o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Takes jobs from the queue and, when not stalled, emits one result beat per
// cycle through an output register; code points become one to four UTF-8 bytes.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_job                   i_q_head,
    output logic                   o_q_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [10:8] error_code
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [1:0] out_kind
    output logic                   m_axis_tlast   // last_of_run
);

    logic            r_valid;
    logic [1:0]      r_idx;
    logic [7:0]      r_byte;
    logic [2:0]      r_code;
    logic [1:0]      r_kind;
    logic            r_last;

    logic [CP_W-1:0] cp;
    logic [1:0]      last_idx;
    logic [7:0]      b_byte;
    logic [2:0]      b_code;
    logic [1:0]      b_kind;
    logic            b_last;
    logic            load;

    assign cp = i_q_head.val;

    // Byte count of the head job, minus one
    always_comb begin
        last_idx = 2'd0;
        if (i_q_head.kind == JOB_CP) begin
            if (cp <= CP_W'(24'h7f)) begin
                last_idx = 2'd0;
            end else if (cp <= CP_W'(24'h7ff)) begin
                last_idx = 2'd1;
            end else if (cp <= CP_W'(24'hffff)) begin
                last_idx = 2'd2;
            end else begin
                last_idx = 2'd3;
            end
        end
    end

    // Beat selected by the byte index
    always_comb begin
        b_byte = 8'd0;
        b_code = 3'd0;
        b_kind = KIND_BYTE;
        case (i_q_head.kind)
            JOB_RAW: begin
                b_byte = cp[7:0];
            end
            JOB_CP: begin
                case (last_idx)
                    2'd0: b_byte = cp[7:0];
                    2'd1: b_byte = (r_idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                    2'd2: begin
                        case (r_idx)
                            2'd0:    b_byte = {4'b1110, cp[15:12]};
                            2'd1:    b_byte = {2'b10, cp[11:6]};
                            default: b_byte = {2'b10, cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (r_idx)
                            2'd0:    b_byte = {5'b11110, cp[20:18]};
                            2'd1:    b_byte = {2'b10, cp[17:12]};
                            2'd2:    b_byte = {2'b10, cp[11:6]};
                            default: b_byte = {2'b10, cp[5:0]};
                        endcase
                    end
                endcase
            end
            JOB_DONE: begin
                b_kind = KIND_DONE;
            end
            default: begin
                b_kind = KIND_ERR;
                b_code = cp[2:0];
            end
        endcase
        b_last = (r_idx == last_idx);
    end

    assign load    = !r_valid || m_axis_tready;
    assign o_q_pop = load && !i_q_empty && b_last;

    // Output beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (!i_q_empty) begin
                r_idx <= b_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_byte <= b_byte;
            r_code <= b_code;
            r_kind <= b_kind;
            r_last <= b_last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_code, r_byte};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

endmodule

// ===== tb/sv/json_string_unescape_utf8_top_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_tb
// Self-checking bench for the streaming JSON string decoder: a behavioral
// decoder predicts every result beat from each accepted source beat, and a
// checker compares the output stream field by field, in order. Directed
// strings cover the idle errors, the simple escapes, a surrogate pair and
// one long output hold-off; random strings with random content, broken
// sequences and noise follow, under random gaps and stalls.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;
    import jsu_pkg::*;

    // Bench limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BEATS = 80;

    // Characters with a meaning to the decoder
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    // Error field of a result that is not an error
    localparam logic [2:0] CODE_NONE = 3'd0;

    // Decoder phases of the predictor
    typedef enum logic [3:0] {
        PH_IDLE, PH_STR, PH_ESC,
        PH_HX0, PH_HX1, PH_HX2, PH_HX3,
        PH_LBS, PH_LU,
        PH_LX0, PH_LX1, PH_LX2, PH_LX3,
        PH_DISCARD
    } t_dec_phase;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
        logic       last;
    } t_dec_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;     // [7:0] in_byte
    logic                   s_axis_tlast = 1'b0;   // end_mark
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [7:0] out_byte, [10:8] error_code
    logic [OUT_TUSER_W-1:0] m_axis_tuser;          // [1:0] out_kind
    logic                   m_axis_tlast;          // last_of_run

    // Predictor state
    t_dec_phase  dec_phase = PH_IDLE;
    logic [15:0] dec_hex   = '0;
    logic [9:0]  dec_high  = '0;
    t_dec_result decoded_q[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int beats_sent     = 0;
    bit tx_gaps_on     = 1'b1;
    bit rx_stalls_on   = 1'b1;
    int rx_stall       = 0;
    int rx_hold        = 0;

    json_string_unescape_utf8_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** json_string_unescape_utf8_top: FAILED **");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void post(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
        t_dec_result item;
        item = '{kind, data, code, 1'b0};
        decoded_q.insert(decoded_q.size(), item);
    endfunction

    function automatic void post_utf8(logic [20:0] cp);
        if (cp < 21'h80) begin
            post(KIND_BYTE, cp[7:0], CODE_NONE);
        end else if (cp < 21'h800) begin
            post(KIND_BYTE, {3'b110, cp[10:6]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
        end else if (cp < 21'h10000) begin
            post(KIND_BYTE, {4'b1110, cp[15:12]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[11:6]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
        end else begin
            post(KIND_BYTE, {5'b11110, cp[20:18]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[17:12]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[11:6]}, CODE_NONE);
            post(KIND_BYTE, {2'b10, cp[5:0]}, CODE_NONE);
        end
    endfunction

    // Error result; an end mark returns to idle, a byte sends to discard
    function automatic void post_error(logic [2:0] code, logic at_end);
        dec_phase = at_end ? PH_IDLE : PH_DISCARD;
        dec_hex   = '0;
        dec_high  = '0;
        post(KIND_ERR, 8'h00, code);
    endfunction

    // -1 for a byte that is no hex digit
    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void decode_source_byte(logic [7:0] c, logic end_mark);
        int         n_before;
        int         nib;
        logic [7:0] simple;
        n_before = decoded_q.size();
        case (dec_phase)
            PH_IDLE: begin
                if (end_mark || c != CH_QUOTE) post_error(ERR_NO_QUOTE, end_mark);
                else dec_phase = PH_STR;
            end
            PH_STR: begin
                if (end_mark) begin
                    post_error(ERR_UNTERM, 1'b1);
                end else if (c == CH_QUOTE) begin
                    post(KIND_DONE, 8'h00, CODE_NONE);
                    dec_phase = PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    post(KIND_BYTE, c, CODE_NONE);
                end
            end
            PH_ESC: begin
                if (end_mark) begin
                    post_error(ERR_UNTERM, 1'b1);
                end else if (c == CH_U) begin
                    dec_hex   = '0;
                    dec_phase = PH_HX0;
                end else begin
                    case (c)
                        CH_QUOTE, CH_BSLASH, "/": simple = c;
                        "b":     simple = 8'h08;
                        "f":     simple = 8'h0c;
                        "n":     simple = 8'h0a;
                        "r":     simple = 8'h0d;
                        "t":     simple = 8'h09;
                        default: simple = 8'hff;
                    endcase
                    if (simple == 8'hff) begin
                        post_error(ERR_BAD_ESC, 1'b0);
                    end else begin
                        post(KIND_BYTE, simple, CODE_NONE);
                        dec_phase = PH_STR;
                    end
                end
            end
            PH_HX0, PH_HX1, PH_HX2, PH_HX3, PH_LX0, PH_LX1, PH_LX2, PH_LX3: begin
                nib = nibble_of(c);
                if (end_mark) begin
                    post_error(ERR_UNTERM, 1'b1);
                end else if (nib < 0) begin
                    post_error(ERR_BAD_HEX, 1'b0);
                end else begin
                    dec_hex = {dec_hex[11:0], 4'(nib)};
                    if (dec_phase != PH_HX3 && dec_phase != PH_LX3) begin
                        dec_phase = t_dec_phase'(dec_phase + 1);
                    end else if (dec_phase == PH_HX3) begin
                        // first half of a pair waits for its low half
                        if (dec_hex >= 16'hd800 && dec_hex <= 16'hdbff) begin
                            dec_high  = dec_hex[9:0];
                            dec_phase = PH_LBS;
                        end else begin
                            post_utf8({5'd0, dec_hex});
                            dec_phase = PH_STR;
                        end
                        dec_hex = '0;
                    end else if (dec_hex >= 16'hdc00 && dec_hex <= 16'hdfff) begin
                        post_utf8(21'h10000 + {1'b0, dec_high, dec_hex[9:0]});
                        dec_hex   = '0;
                        dec_high  = '0;
                        dec_phase = PH_STR;
                    end else begin
                        post_error(ERR_BAD_LOW, 1'b0);
                    end
                end
            end
            PH_LBS: begin
                if (end_mark) post_error(ERR_NO_LOW, 1'b1);
                else if (c == CH_BSLASH) dec_phase = PH_LU;
                else post_error(ERR_NO_LOW, 1'b0);
            end
            PH_LU: begin
                if (end_mark) begin
                    post_error(ERR_NO_LOW, 1'b1);
                end else if (c == CH_U) begin
                    dec_hex   = '0;
                    dec_phase = PH_LX0;
                end else begin
                    post_error(ERR_NO_LOW, 1'b0);
                end
            end
            default: begin
                // discarding until the end mark
                if (end_mark) begin
                    dec_phase = PH_IDLE;
                    dec_hex   = '0;
                    dec_high  = '0;
                end
            end
        endcase
        if (decoded_q.size() > n_before) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    // Input monitor: predict on every accepted source beat
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            decode_source_byte(s_axis_tdata, s_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result beat with none expected: kind %0d byte 0x%02h code %0d",
                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8]);
                mismatch_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_kind", want.kind, m_axis_tuser);
                check_field("out_byte", want.data, m_axis_tdata[7:0]);
                check_field("error_code", want.code, m_axis_tdata[10:8]);
                check_field("last_of_run", want.last, m_axis_tlast);
            end
        end
    end

    // Receiver: random stalls, plus an explicit hold-off counted here
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready = 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] data, input logic end_mark);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tlast  = end_mark;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic stream_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_beat(s[i], 1'b0);
    endtask

    // in_byte is ignored with the end mark, so it carries noise
    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    task automatic send_u(input logic [15:0] v);
        send_beat(CH_BSLASH, 1'b0);
        send_beat(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) send_beat(hex_char(v[i*4 +: 4]), 1'b0);
    endtask

    function automatic logic [7:0] byte_except(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] bad_escape_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == CH_U);
        return c;
    endfunction

    function automatic logic [15:0] high_half_value();
        return 16'hd800 + 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] low_half_value();
        return 16'hdc00 + 16'($urandom_range(0, 1023));
    endfunction

    // A valid token inside an open string
    task automatic send_good_token();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: send_beat(byte_except(CH_QUOTE, CH_BSLASH), 1'b0);
            4, 5: begin
                send_beat(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 7))
                    0: send_beat(CH_QUOTE, 1'b0);
                    1: send_beat(CH_BSLASH, 1'b0);
                    2: send_beat("/", 1'b0);
                    3: send_beat("b", 1'b0);
                    4: send_beat("f", 1'b0);
                    5: send_beat("n", 1'b0);
                    6: send_beat("r", 1'b0);
                    default: send_beat("t", 1'b0);
                endcase
            end
            6: begin
                // one, two or three byte code point outside the surrogates
                case ($urandom_range(0, 3))
                    0: v = 16'($urandom_range(0, 16'h7f));
                    1: v = 16'($urandom_range(16'h80, 16'h7ff));
                    2: v = 16'($urandom_range(16'h800, 16'hd7ff));
                    default: v = 16'($urandom_range(16'he000, 16'hffff));
                endcase
                send_u(v);
            end
            7: begin
                send_u(high_half_value());
                send_u(low_half_value());
            end
            8: send_u(low_half_value());    // lone low surrogate
            default: begin
                // control bytes and the high range pass through raw
                if ($urandom_range(0, 1)) send_beat(8'($urandom_range(0, 8'h1f)), 1'b0);
                else send_beat(8'($urandom_range(8'h80, 8'hff)), 1'b0);
            end
        endcase
    endtask

    // A broken sequence; returns 1 when the end mark already closed it
    task automatic send_bad_token(output bit closed);
        logic [15:0] v;
        int          k;
        closed = 1'b0;
        case ($urandom_range(0, 7))
            0: begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat(bad_escape_byte(), 1'b0);
            end
            1: begin
                // bad digit in the first or the low-half hex group
                if ($urandom_range(0, 1)) send_u(high_half_value());
                send_beat(CH_BSLASH, 1'b0);
                send_beat(CH_U, 1'b0);
                k = $urandom_range(0, 3);
                repeat (k) send_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
                send_beat(non_hex_byte(), 1'b0);
            end
            2: begin
                send_u(high_half_value());
                send_beat(byte_except(CH_BSLASH, CH_BSLASH), 1'b0);
            end
            3: begin
                send_u(high_half_value());
                send_beat(CH_BSLASH, 1'b0);
                send_beat(byte_except(CH_U, CH_U), 1'b0);
            end
            4: begin
                // high half followed by something that is not a low half
                send_u(high_half_value());
                do v = 16'($urandom_range(0, 16'hffff)); while (v >= 16'hdc00 && v <= 16'hdfff);
                send_u(v);
            end
            5: begin
                send_u(high_half_value());
                if ($urandom_range(0, 1)) send_beat(CH_BSLASH, 1'b0);
                send_end();
                closed = 1'b1;
            end
            default: begin
                // end mark inside an escape or its hex digits
                send_beat(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_beat(CH_U, 1'b0);
                    k = $urandom_range(0, 3);
                    repeat (k) send_beat(hex_char(4'($urandom_range(0, 15))), 1'b0);
                end
                send_end();
                closed = 1'b1;
            end
        endcase
    endtask

    // Bytes dropped while discarding, then the end mark
    task automatic send_discard_tail();
        int k;
        k = $urandom_range(0, 3);
        repeat (k) send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_end();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_errors();
        send_end();                 // end mark in idle
        send_text("x");             // no opening quote
        send_beat(8'hff, 1'b0);     // dropped
        send_end();                 // back to idle, no result
        send_text("\"");
        send_end();                 // unterminated string
        stream_idle();
    endtask

    task automatic test_escapes_and_pairs();
        send_text("\"");
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b0);
        send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
        send_u(16'hd83d);
        send_u(16'hde00);
        send_text("\"");
        stream_idle();
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        rx_hold    = 150;
        send_text("\"");
        repeat (36) send_beat(byte_except(CH_QUOTE, CH_BSLASH), 1'b0);
        send_u(16'h20ac);
        send_text("\"");
        stream_idle();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_strings();
        int target;
        int r;
        int n_tokens;
        bit closed;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            // some strings run with no idling on either side
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 6) begin
                send_beat(byte_except(CH_QUOTE, CH_QUOTE), 1'b0);
                send_discard_tail();
            end else begin
                send_beat(CH_QUOTE, 1'b0);
                n_tokens = $urandom_range(1, 8);
                repeat (n_tokens) send_good_token();
                r = $urandom_range(0, 99);
                if (r < 68) begin
                    send_beat(CH_QUOTE, 1'b0);
                    if ($urandom_range(0, 99) < 15) send_end();
                end else if (r < 76) begin
                    send_end();
                end else begin
                    send_bad_token(closed);
                    if (!closed) send_discard_tail();
                end
            end
        end
        stream_idle();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_errors();
        test_escapes_and_pairs();
        test_backpressure();
        test_random_strings();

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** json_string_unescape_utf8_top: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8_top: FAILED **");
        end
        $finish;
    end

endmodule
